>>> rtl/core/gbn_pkg.sv
// Shared types, register codes and weight helpers for the Gaussian blur block.
`timescale 1ns / 1ps
package gbn_pkg;

    localparam int HW = 11;    // row counter / effective height width
    localparam int CFGW = 11;  // configuration data width
    localparam int CFG_IDXW = 2;

    localparam logic [CFG_IDXW-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDXW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDXW-1:0] CFG_COLOR_MODE = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // per-lane control from the tap sequencer
    typedef struct packed {
        logic       clr;   // start of a new window
        logic       acc;   // accumulate current tap
        logic       step;  // one quotient bit
        logic [2:0] k;     // quotient bit index
    } t_lane_ctl;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] gbn_udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], a[k]};
            if (rem >= {1'b0, b}) begin
                rem = rem - {1'b0, b};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-d/den) as unsigned Q24.40, alternating series with truncated terms
    function automatic logic [63:0] gbn_exp_q40(input logic [63:0] d, input logic [63:0] den);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 40;
        pos = term;
        neg = '0;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                term = gbn_udiv(term * d, 64'(n) * den);
                if (n % 2 == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
        end
        return pos - neg;
    endfunction

endpackage

>>> rtl/core/gaussian_blur_border_normalized.sv
// Top level: streaming border-normalized Gaussian blur over a line store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  input   | in        | i_valid / o_stall   | i_kind, i_red_or_gray, i_green_in, i_blue_in
//  output  | out       | o_valid / i_stall   | o_red_or_gray_out, o_green_out, o_blue_out,
//          |           |                     | o_frame_last
//  config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// A transaction that produces a result makes one line-store read per window tap,
// drains the read, runs eight divide steps and loads the output register once
// that register is not held by a stalled result.
// The three color lanes run side by side on every tap; the output register merges them.
// Reset is synchronous active low and clears counters and control; RAM is not cleared.
// A result waiting in the output register under stall does not block the next input.
`timescale 1ns / 1ps
module gaussian_blur_border_normalized import gbn_pkg::*; #(
    parameter int RADIUS = 2,
    parameter int MAX_WIDTH = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [7:0]          i_red_or_gray,
    input  logic [7:0]          i_green_in,
    input  logic [7:0]          i_blue_in,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_red_or_gray_out,
    output logic [7:0]          o_green_out,
    output logic [7:0]          o_blue_out,
    output logic                o_frame_last,
    input  logic                i_cfg_we,
    input  logic [CFG_IDXW-1:0] i_cfg_index,
    input  logic [CFGW-1:0]     i_cfg_data
);

    localparam int SPAN = 2 * RADIUS + 1;
    localparam int SLOTS = 2 * RADIUS + 2;
    localparam int NTAP = SPAN * SPAN;
    localparam int TW = $clog2(NTAP);
    localparam int XW = $clog2(SPAN);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > CFGW) ? WW : CFGW;
    localparam int XSW = CW + 2;
    localparam int YSW = HW + 1;
    localparam int LGW = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int WTW = WEIGHT_BITS + 1;
    localparam int WSW = WTW + TW;
    localparam int AW = WSW + 8;
    localparam int ADW = SW + CW;
    localparam int DEPTH = SLOTS * (1 << CW);

    // weight table, tap index = row * SPAN + column
    function automatic logic [NTAP*WTW-1:0] build_wtab();
        logic [NTAP*WTW-1:0] tab;
        logic [63:0] e;
        logic [63:0] wt;
        int di;
        int dj;
        tab = '0;
        for (int j = 0; j < SPAN; j++) begin
            for (int i = 0; i < SPAN; i++) begin
                di = (i > RADIUS) ? i - RADIUS : RADIUS - i;
                dj = (j > RADIUS) ? j - RADIUS : RADIUS - j;
                e = gbn_exp_q40(64'(di * di + dj * dj), 64'(2 * RADIUS * RADIUS));
                wt = (e + (64'd1 << (39 - WEIGHT_BITS))) >> (40 - WEIGHT_BITS);
                tab[(j * SPAN + i) * WTW +: WTW] = wt[WTW-1:0];
            end
        end
        return tab;
    endfunction

    localparam logic [NTAP*WTW-1:0] WTAB = build_wtab();

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TAP  = 5'b00010,
        S_LAST = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state            r_state;
    logic [CFGW-1:0]   r_width;
    logic [CFGW-1:0]   r_height;
    logic              r_color;
    logic [CW-1:0]     r_in_col;
    logic [HW-1:0]     r_in_row;
    logic [SW-1:0]     r_in_slot;
    logic [CW-1:0]     r_out_col;
    logic [HW-1:0]     r_out_row;
    logic [SW-1:0]     r_out_slot;
    logic [LGW-1:0]    r_cnt;
    logic [XW-1:0]     r_tx;
    logic [XW-1:0]     r_ty;
    logic [TW-1:0]     r_tap;
    logic [SW-1:0]     r_tslot;
    logic [2:0]        r_k;
    logic              r_p_vld;
    logic              r_p_ok;
    logic [WTW-1:0]    r_p_w;
    logic [WSW-1:0]    r_wsum;
    logic              r_o_valid;
    logic [7:0]        r_o_r;
    logic [7:0]        r_o_g;
    logic [7:0]        r_o_b;
    logic              r_o_last;

    // effective frame geometry
    logic [EW-1:0]     wclamp;
    logic [WW-1:0]     eff_w;
    logic [HW-1:0]     eff_h;
    logic [LGW-1:0]    lag;
    logic              in_acc;
    logic              out_free;
    logic              frame_done;
    logic              start_emit;
    logic              pix_write;
    logic              last_pix;
    logic [SW:0]       n_tslot;
    logic [XSW-1:0]    sx;
    logic [YSW-1:0]    sy;
    logic              tap_ok;
    logic [ADW-1:0]    raddr;
    logic [ADW-1:0]    waddr;
    logic [23:0]       rdata;
    t_lane_ctl         lane_ctl;
    logic [7:0]        quot [3];

    always_comb begin
        wclamp = EW'(r_width);
        if (wclamp == '0) begin
            wclamp = EW'(1);
        end else if (wclamp > EW'(MAX_WIDTH)) begin
            wclamp = EW'(MAX_WIDTH);
        end
    end
    assign eff_w = wclamp[WW-1:0];
    assign eff_h = (r_height == '0) ? HW'(1) : r_height;
    assign lag = LGW'(RADIUS * eff_w) + LGW'(RADIUS);

    assign o_stall = (r_state != S_IDLE);
    assign in_acc = i_valid && !o_stall;
    assign frame_done = (r_in_row >= eff_h);
    assign pix_write = in_acc && (i_kind == KIND_PIXEL) && !frame_done;
    assign start_emit = (pix_write && (r_cnt >= lag)) ||
                        (in_acc && (i_kind == KIND_DRAIN) && frame_done);
    assign last_pix = (r_in_col == CW'(eff_w - WW'(1)));
    assign out_free = !r_o_valid || !i_stall;

    // first window row slot: (out_slot - R) mod SLOTS
    always_comb begin
        n_tslot = (SW+1)'(r_out_slot) + (SW+1)'(SLOTS - RADIUS);
        if (n_tslot >= (SW+1)'(SLOTS)) begin
            n_tslot = n_tslot - (SW+1)'(SLOTS);
        end
    end

    // tap position, shifted by +R so bounds checks stay unsigned
    assign sx = XSW'(r_out_col) + XSW'(r_tx);
    assign sy = YSW'(r_out_row) + YSW'(r_ty);
    assign tap_ok = (sx >= XSW'(RADIUS)) && (sx < XSW'(eff_w) + XSW'(RADIUS)) &&
                    (sy >= YSW'(RADIUS)) && (sy < YSW'(eff_h) + YSW'(RADIUS));
    assign raddr = {r_tslot, CW'(sx - XSW'(RADIUS))};
    assign waddr = {r_in_slot, r_in_col};

    gbn_line_mem #(
        .DEPTH(DEPTH),
        .ADW(ADW)
    ) u_mem (
        .i_clk(i_clk),
        .i_we(pix_write),
        .i_waddr(waddr),
        .i_wdata({i_blue_in, i_green_in, i_red_or_gray}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        lane_ctl.clr = start_emit;
        lane_ctl.acc = r_p_vld && r_p_ok;
        lane_ctl.step = (r_state == S_DIV);
        lane_ctl.k = r_k;
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        gbn_lane #(
            .WTW(WTW),
            .WSW(WSW),
            .AW(AW)
        ) u_lane (
            .i_clk(i_clk),
            .i_ctl(lane_ctl),
            .i_pix(rdata[8*c +: 8]),
            .i_weight(r_p_w),
            .i_wsum(r_wsum),
            .o_quot(quot[c])
        );
    end

    // sequencer and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= CFGW'(640);
            r_height <= CFGW'(480);
            r_color <= 1'b0;
            r_in_col <= '0;
            r_in_row <= '0;
            r_in_slot <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_slot <= '0;
            r_cnt <= '0;
            r_tx <= '0;
            r_ty <= '0;
            r_tap <= '0;
            r_tslot <= '0;
            r_k <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= 1'b0;
            if (i_cfg_we && (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT ||
                             i_cfg_index == CFG_COLOR_MODE)) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default:          r_color <= i_cfg_data[0];
                endcase
                r_in_col <= '0;
                r_in_row <= '0;
                r_in_slot <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_out_slot <= '0;
                r_cnt <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (pix_write) begin
                            if (r_cnt < lag) begin
                                r_cnt <= r_cnt + LGW'(1);
                            end
                            if (last_pix) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + HW'(1);
                                r_in_slot <= (r_in_slot == SW'(SLOTS - 1)) ? '0
                                                                          : r_in_slot + SW'(1);
                            end else begin
                                r_in_col <= r_in_col + CW'(1);
                            end
                        end
                        if (start_emit) begin
                            r_state <= S_TAP;
                            r_tx <= '0;
                            r_ty <= '0;
                            r_tap <= '0;
                            r_tslot <= n_tslot[SW-1:0];
                        end
                    end
                    S_TAP: begin
                        r_p_vld <= 1'b1;
                        r_tap <= r_tap + TW'(1);
                        if (r_tx == XW'(SPAN - 1)) begin
                            r_tx <= '0;
                            r_ty <= r_ty + XW'(1);
                            r_tslot <= (r_tslot == SW'(SLOTS - 1)) ? '0 : r_tslot + SW'(1);
                            if (r_ty == XW'(SPAN - 1)) begin
                                r_state <= S_LAST;
                            end
                        end else begin
                            r_tx <= r_tx + XW'(1);
                        end
                    end
                    S_LAST: begin
                        r_state <= S_DIV;
                        r_k <= 3'd7;
                    end
                    S_DIV: begin
                        r_k <= r_k - 3'd1;
                        if (r_k == 3'd0) begin
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        if (out_free) begin
                            r_state <= S_IDLE;
                            if (r_out_row == eff_h - HW'(1) &&
                                r_out_col == CW'(eff_w - WW'(1))) begin
                                // frame complete, start over
                                r_in_col <= '0;
                                r_in_row <= '0;
                                r_in_slot <= '0;
                                r_out_col <= '0;
                                r_out_row <= '0;
                                r_out_slot <= '0;
                                r_cnt <= '0;
                            end else if (r_out_col == CW'(eff_w - WW'(1))) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + HW'(1);
                                r_out_slot <= (r_out_slot == SW'(SLOTS - 1)) ? '0
                                                                            : r_out_slot + SW'(1);
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // tap pipeline alongside the RAM read, and the in-bounds weight sum
    always_ff @(posedge i_clk) begin
        r_p_ok <= tap_ok;
        r_p_w <= WTAB[r_tap * WTW +: WTW];
        if (start_emit) begin
            r_wsum <= '0;
        end else if (r_p_vld && r_p_ok) begin
            r_wsum <= r_wsum + WSW'(r_p_w);
        end
    end

    // output register merges the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_r <= quot[0];
            r_o_g <= r_color ? quot[1] : 8'd0;
            r_o_b <= r_color ? quot[2] : 8'd0;
            r_o_last <= (r_out_row == eff_h - HW'(1)) && (r_out_col == CW'(eff_w - WW'(1)));
        end
    end

    assign o_valid = r_o_valid;
    assign o_red_or_gray_out = r_o_r;
    assign o_green_out = r_o_g;
    assign o_blue_out = r_o_b;
    assign o_frame_last = r_o_last;

endmodule

>>> rtl/core/gbn_line_mem.sv
// Line store: simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gbn_line_mem import gbn_pkg::*; #(
    parameter int DEPTH = 6144,
    parameter int ADW = 13
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [ADW-1:0] i_waddr,
    input  logic [23:0]    i_wdata,
    input  logic [ADW-1:0] i_raddr,
    output logic [23:0]    o_rdata
);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/gbn_lane.sv
// One color lane: weighted accumulate, then 8-step restoring divide.
`timescale 1ns / 1ps
module gbn_lane import gbn_pkg::*; #(
    parameter int WTW = 17,
    parameter int WSW = 22,
    parameter int AW = 30
) (
    input  logic           i_clk,
    input  t_lane_ctl      i_ctl,
    input  logic [7:0]     i_pix,
    input  logic [WTW-1:0] i_weight,
    input  logic [WSW-1:0] i_wsum,
    output logic [7:0]     o_quot
);

    logic [AW-1:0]    r_acc;
    logic [7:0]       r_quot;
    logic [WTW+7:0]   prod;
    logic [AW-1:0]    trial;

    assign prod = i_weight * i_pix;
    assign trial = AW'(i_wsum) << i_ctl.k;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
            r_quot <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + AW'(prod);
        end else if (i_ctl.step) begin
            if (r_acc >= trial) begin
                r_acc <= r_acc - trial;
                r_quot[i_ctl.k] <= 1'b1;
            end
        end
    end

    assign o_quot = r_quot;

endmodule

>>> rtl/core/gbn_checker.sv
// Port-level checks for the Gaussian blur block, bound to the top level.
`timescale 1ns / 1ps
module gbn_checker import gbn_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [7:0]          o_red_or_gray_out,
    input logic [7:0]          o_green_out,
    input logic [7:0]          o_blue_out,
    input logic                o_frame_last,
    input logic                i_cfg_we,
    input logic [CFG_IDXW-1:0] i_cfg_index,
    input logic [CFGW-1:0]     i_cfg_data
);

    logic r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we && i_cfg_index == CFG_COLOR_MODE) begin
            r_mode <= i_cfg_data[0];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_or_gray_out) && $stable(o_frame_last))
        else $error("result changed while stalled");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_mode |-> o_green_out == 8'd0 && o_blue_out == 8'd0)
        else $error("color channels nonzero in gray mode");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a window pass");

endmodule

bind gaussian_blur_border_normalized gbn_checker u_gbn_checker (.*);
